### hw/rtl/sitda_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal text block.
// ---------------------------------------------------------------------------
package sitda_pkg;

   localparam int ValueWidth = 32;
   localparam int CharWidth  = 8;
   localparam int NumDigits  = 10;
   localparam int BcdWidth   = 4 * NumDigits;
   localparam int StepWidth  = $clog2(ValueWidth);
   localparam int CountWidth = $clog2(NumDigits + 1);

   localparam logic [CharWidth-1:0] CharZero  = 8'd48;
   localparam logic [CharWidth-1:0] CharMinus = 8'd45;

   typedef struct packed {
      logic load;
      logic step;
      logic shift_digit;
      logic emit_sign;
      logic emit_digit;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic top_zero;
      logic negative;
   } status_type;

endpackage

### hw/rtl/sitda_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sitda_dp
// Datapath: magnitude, shift-add-3 binary to bcd, digit shifter and the
// output character register.
// ---------------------------------------------------------------------------
module sitda_dp (
   input  logic                                 clock,
   input  logic signed [sitda_pkg::ValueWidth-1:0] req_value,
   input  sitda_pkg::cmd_type                   cmd,
   output sitda_pkg::status_type                status,
   output logic        [sitda_pkg::CharWidth-1:0]  rsp_character,
   output logic                                 rsp_last
);
   import sitda_pkg::*;

   logic [ValueWidth-1:0] mag_ff, mag_in;
   logic [BcdWidth-1:0]   bcd_ff, bcd_in;
   logic                  neg_ff, neg_in;
   logic [CharWidth-1:0]  char_ff, char_in;
   logic                  last_ff, last_in;
   logic [BcdWidth-1:0]   bcd_adj;
   logic [ValueWidth-1:0] raw;

   assign raw = ValueWidth'(req_value);

   // add 3 to every digit of five or more
   always_comb begin
      for (int i = 0; i < NumDigits; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      neg_in  = neg_ff;
      char_in = char_ff;
      last_in = last_ff;
      if (cmd.load) begin
         neg_in = raw[ValueWidth-1];
         mag_in = raw[ValueWidth-1] ? (~raw + ValueWidth'(1)) : raw;
         bcd_in = '0;
      end else if (cmd.step) begin
         {bcd_in, mag_in} = {bcd_adj[BcdWidth-2:0], mag_ff, 1'b0};
      end
      if (cmd.emit_sign) begin
         char_in = CharMinus;
         last_in = cmd.last;
      end else if (cmd.emit_digit) begin
         char_in = CharZero + {4'd0, bcd_ff[BcdWidth-1 -: 4]};
         last_in = cmd.last;
      end
      if (cmd.shift_digit) begin
         bcd_in = {bcd_ff[BcdWidth-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign status.top_zero = (bcd_ff[BcdWidth-1 -: 4] == 4'd0);
   assign status.negative = neg_ff;
   assign rsp_character   = char_ff;
   assign rsp_last        = last_ff;

endmodule

### hw/rtl/sitda_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sitda_ctrl
// Controller: sequences load, conversion steps, leading zero trim and
// character output, and owns both handshakes.
// ---------------------------------------------------------------------------
module sitda_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  sitda_pkg::status_type status,
   output sitda_pkg::cmd_type    cmd
);
   import sitda_pkg::*;

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StConv  = 3'd1;
   localparam logic [2:0] StTrim  = 3'd2;
   localparam logic [2:0] StSign  = 3'd3;
   localparam logic [2:0] StDigit = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  valid_ff, valid_in;
   logic                  out_free;

   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == StIdle);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      count_in = count_ff;
      cmd      = '0;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = StConv;
            end
         end
         StConv: begin
            cmd.step = 1'b1;
            step_in  = step_ff + StepWidth'(1);
            if (step_ff == StepWidth'(ValueWidth - 1)) begin
               count_in = CountWidth'(NumDigits);
               state_in = StTrim;
            end
         end
         StTrim: begin
            if (status.top_zero && count_ff > CountWidth'(1)) begin
               cmd.shift_digit = 1'b1;
               count_in        = count_ff - CountWidth'(1);
            end else if (status.negative) begin
               state_in = StSign;
            end else begin
               state_in = StDigit;
            end
         end
         StSign: begin
            if (out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = StDigit;
            end
         end
         StDigit: begin
            if (out_free) begin
               cmd.emit_digit  = 1'b1;
               cmd.shift_digit = 1'b1;
               cmd.last        = (count_ff == CountWidth'(1));
               count_in        = count_ff - CountWidth'(1);
               if (count_ff == CountWidth'(1)) begin
                  state_in = StIdle;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit_sign || cmd.emit_digit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         step_ff  <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

### hw/rtl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ascii text, one character
// per output word, most significant first, with a minus sign when negative.
//
//   channel   ports                          carries
//   req       req_valid/ready, req_value     one signed 32-bit value
//   rsp       rsp_valid/ready, rsp_character one character, last flag
//             rsp_last
//
// one word takes a load, one shift-add-3 step per value bit, leading zero
// trim, then its characters (up to 11), a minus sign first when negative.
// reset is synchronous and clears the controller and the output valid.
// a stalled rsp holds the current character; character output waits for it.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [sitda_pkg::ValueWidth-1:0] req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic        [sitda_pkg::CharWidth-1:0]  rsp_character,
   output logic                                    rsp_last
);
   import sitda_pkg::*;

   cmd_type    cmd;
   status_type status;

   sitda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sitda_dp u_dp (
      .clock         (clock),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

### test/decimal_text_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_text_checker
// Watches the value and character channels of the integer to decimal text
// block. Every accepted value is turned into its expected run of characters.
// Every accepted character is compared with the oldest one still due.
// ---------------------------------------------------------------------------
module decimal_text_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic signed [sitda_pkg::ValueWidth-1:0] req_value,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic        [sitda_pkg::CharWidth-1:0]  rsp_character,
   input  logic                                    rsp_last,
   output int                                      fail_count,
   output int                                      pending_count
);
   import sitda_pkg::*;

   typedef struct {
      logic        [CharWidth-1:0]  character;
      logic                         last;
      logic signed [ValueWidth-1:0] source;
   } text_char_type;

   text_char_type expected_text[$];

   function automatic void predict_text(input logic signed [ValueWidth-1:0] value);
      logic [ValueWidth:0] magnitude;
      logic [3:0]          digit_stack [NumDigits];
      text_char_type       entry;
      int                  count;
      int                  i;
      if (value[ValueWidth-1]) begin
         magnitude = (33'h1 << ValueWidth) - {1'b0, value};
      end else begin
         magnitude = {1'b0, value};
      end
      count = 0;
      do begin
         digit_stack[count] = 4'(magnitude % 10);
         magnitude = magnitude / 10;
         count++;
      end while (magnitude != 0);
      entry.source = value;
      if (value[ValueWidth-1]) begin
         entry.character = CharMinus;
         entry.last = 1'b0;
         expected_text.push_back(entry);
      end
      for (i = count - 1; i >= 0; i--) begin
         entry.character = CharZero + {4'b0000, digit_stack[i]};
         entry.last = (i == 0);
         expected_text.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin
      text_char_type due;
      if (reset) begin
         expected_text.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               if (fail_count < 10) begin
                  $display("%0t: unexpected word: character %0d last %0b", $realtime,
                           rsp_character, rsp_last);
               end
               fail_count <= fail_count + 1;
            end else begin
               due = expected_text.pop_front();
               if (rsp_character !== due.character || rsp_last !== due.last) begin
                  if (fail_count < 10) begin
                     $display("%0t: value %0d: expected character %0d last %0b, got %0d %0b",
                              $realtime, due.source, due.character, due.last,
                              rsp_character, rsp_last);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_text(req_value);
         end
         pending_count <= expected_text.size();
      end
   end

endmodule

### test/signed_int_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Drives signed values into the decimal text block: a directed set of edge
// values, then random values of every length and sign, with random gaps on
// both channels. The checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;
   import sitda_pkg::*;

   localparam int RandomValues = 258;
   localparam int CycleLimit   = 1000000;
   localparam int DrainCycles  = 80;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [ValueWidth-1:0] req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic        [CharWidth-1:0]  rsp_character;
   logic                         rsp_last;
   int                           fail_count;
   int                           pending_count;
   int                           cycle_count = 0;
   int                           rsp_hold = 0;
   logic                         calm = 1'b0;

   logic [ValueWidth-1:0] directed_values [22] = '{
      32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
      32'd100, -32'sd100, 32'd12345, -32'sd67890, 32'd999999999, 32'd1000000000,
      -32'sd1000000000, -32'sd999999999, 32'h7FFF_FFFF, 32'h8000_0001,
      32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd2000000000
   };

   signed_int_to_decimal_ascii uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   decimal_text_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic longint ten_to(input int power);
      longint result;
      result = 1;
      repeat (power) result = result * 10;
      return result;
   endfunction

   function automatic logic [ValueWidth-1:0] random_value();
      longint magnitude;
      int     digits;
      case ($urandom_range(0, 5))
         0, 1: begin
            return $urandom;
         end
         2: begin
            magnitude = $urandom_range(0, 200);
         end
         3: begin
            magnitude = ten_to($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
         end
         4: begin
            digits = $urandom_range(1, 10);
            if (digits == 10) begin
               magnitude = $urandom_range(1000000000, 32'h7FFF_FFFF);
            end else begin
               magnitude = $urandom_range(32'(ten_to(digits - 1)),
                                          32'(ten_to(digits) - 1));
            end
         end
         default: begin
            magnitude = 64'h8000_0000 - $urandom_range(0, 20);
         end
      endcase
      if ($urandom_range(0, 1) == 1) begin
         return ValueWidth'(-magnitude);
      end
      return ValueWidth'(magnitude);
   endfunction

   // called at a rising edge; returns at the edge that accepts the word
   task automatic send_value(input logic [ValueWidth-1:0] value);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         req_value <= $urandom;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold <= calm ? 0 : pick_gap();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_values[i]) begin
         send_value(directed_values[i]);
      end
      for (n = 0; n < RandomValues; n++) begin
         if (n % 40 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
         end
         send_value(random_value());
      end
      req_valid <= 1'b0;
      calm = 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
